### hdl/top_k_magnitude_selector_unit_macros.svh
// Assertion macros for the top-k magnitude selector.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TOP_K_MAGNITUDE_SELECTOR_UNIT_MACROS_SVH
`define TOP_K_MAGNITUDE_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TKMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TKMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tkms_pkg.sv
// Shared widths, constants and types of the top-k magnitude selector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tkms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 12;
  localparam int MAG_W    = 16;
  localparam int TC_W     = 5;

  localparam logic [TC_W-1:0] TOP_COUNT_RST = 5'd16;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // One classified sample handed from front to back
  typedef struct packed {
    logic             ins;   // sample is within capacity and joins the ranking
    logic             last;  // closes the set
    logic             ovf;   // sticky overflow of the set, valid with last
    logic [IDX_W-1:0] idx;
    logic [MAG_W-1:0] mag;
  } tkms_item_t;

  // One ranked entry
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [MAG_W-1:0] mag;
  } tkms_slot_t;

  // Back-end state, one-hot
  typedef enum logic [1:0] {
    ST_INS = 2'b01,
    ST_OUT = 2'b10
  } tkms_state_e;

endpackage

### hdl/tkms_queue.sv
// Short FIFO that decouples the classifying front from the ranking back.
// Depends on tkms_pkg for the item type and depth constants.
`timescale 1ns / 1ps

module tkms_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tkms_pkg::tkms_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output tkms_pkg::tkms_item_t head_o
);
  import tkms_pkg::*;

  tkms_item_t         mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_q, wptr_d;
  logic [Q_PTR_W-1:0] rptr_q, rptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

### hdl/tkms_front.sv
// Front end: takes samples, numbers them, forms magnitudes and tracks overflow.
// Depends on tkms_pkg; feeds tkms_queue.
`timescale 1ns / 1ps

module tkms_front #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic signed [tkms_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                              last_sample_i,
  output logic                              push_o,
  output tkms_pkg::tkms_item_t              item_o
);
  import tkms_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             in_range;
  logic             ovf_now;
  logic [MAG_W-1:0] mag;

  // Absolute value; the most negative sample maps to 0x8000
  assign mag = sample_i[SAMPLE_W-1] ? MAG_W'(~sample_i + 1'b1) : MAG_W'(sample_i);

  assign in_range = (cnt_q < CNT_W'(MAX_SAMPLES));
  assign ovf_now  = ovf_q || !in_range;

  // Hand over samples that rank or that close the set
  assign push_o      = accept_i && (in_range || last_sample_i);
  assign item_o.ins  = in_range;
  assign item_o.last = last_sample_i;
  assign item_o.ovf  = ovf_now;
  assign item_o.idx  = IDX_W'(cnt_q);
  assign item_o.mag  = mag;

  // Count the set and hold overflow until the set closes
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept_i) begin
      if (last_sample_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (in_range) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

### hdl/tkms_rank.sv
// Back end: compare-and-shift ranking cells and the result sequencer.
// Depends on tkms_pkg and the assertion macro header; drains tkms_queue.
`timescale 1ns / 1ps

module tkms_rank #(
  parameter int TOP_SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tkms_pkg::TC_W-1:0]    top_count_i,
  input  logic                         q_valid_i,
  input  tkms_pkg::tkms_item_t         q_head_i,
  output logic                         q_pop_o,
  output logic                         result_valid_o,
  output logic [tkms_pkg::IDX_W-1:0]   channel_index_o,
  output logic [tkms_pkg::MAG_W-1:0]   magnitude_o,
  output logic                         overflow_o,
  output logic                         last_result_o
);
  import tkms_pkg::*;
  `include "top_k_magnitude_selector_unit_macros.svh"

  localparam int KW    = $clog2(TOP_SLOTS + 1);
  localparam int CMP_W = (KW > TC_W) ? KW : TC_W;

  tkms_state_e          state_q, state_d;
  tkms_slot_t           slot_q [TOP_SLOTS];
  tkms_slot_t           slot_d [TOP_SLOTS];
  tkms_slot_t           ins_slot [TOP_SLOTS];
  tkms_slot_t           shf_slot [TOP_SLOTS];
  tkms_slot_t           new_slot;
  logic [TOP_SLOTS-1:0] valid_q, valid_d;
  logic [TOP_SLOTS-1:0] ins_valid;
  logic [TOP_SLOTS-1:0] shf_valid;
  logic [TOP_SLOTS-1:0] ge;
  logic [KW-1:0]        k_q, k_d;
  logic                 set_ovf_q, set_ovf_d;
  logic [CMP_W-1:0]     k_ext, tc_ext;
  logic                 emit_ok, is_last;
  logic                 strobe_d;
  logic                 strobe_q;
  logic                 last_q;
  logic [IDX_W-1:0]     idx_q;
  logic [MAG_W-1:0]     mag_q;
  logic                 ovf_res_q;
  logic                 pop;

  assign new_slot = '{idx: q_head_i.idx, mag: q_head_i.mag};

  // Ranking cells: each keeps, takes the new sample, or takes its upper neighbor
  for (genvar gi = 0; gi < TOP_SLOTS; gi++) begin : g_cell
    assign ge[gi] = valid_q[gi] && (slot_q[gi].mag >= q_head_i.mag);
    if (gi == 0) begin : g_head
      assign ins_valid[gi] = 1'b1;
      assign ins_slot[gi]  = ge[gi] ? slot_q[gi] : new_slot;
    end else begin : g_body
      assign ins_valid[gi] = valid_q[gi] || valid_q[gi-1];
      assign ins_slot[gi]  = ge[gi]   ? slot_q[gi] :
                             ge[gi-1] ? new_slot :
                                        slot_q[gi-1];
    end
    if (gi < TOP_SLOTS - 1) begin : g_shift
      assign shf_slot[gi] = slot_q[gi+1];
    end else begin : g_tail
      assign shf_slot[gi] = slot_q[gi];
    end
  end

  // Shift toward the head while reporting
  assign shf_valid = valid_q >> 1;

  assign pop     = (state_q == ST_INS) && q_valid_i;
  assign q_pop_o = pop;

  assign k_ext   = CMP_W'(k_q);
  assign tc_ext  = CMP_W'(top_count_i);
  assign emit_ok = valid_q[0] && (k_ext < tc_ext);
  assign is_last = (CMP_W'(k_ext + 1'b1) == tc_ext) || !shf_valid[0];

  // Sequence insertion and reporting
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    slot_d    = slot_q;
    k_d       = k_q;
    set_ovf_d = set_ovf_q;
    strobe_d  = 1'b0;
    unique case (state_q)
      ST_INS: begin
        if (pop) begin
          if (q_head_i.ins) begin
            valid_d = ins_valid;
            slot_d  = ins_slot;
          end
          if (q_head_i.last) begin
            state_d   = ST_OUT;
            k_d       = '0;
            set_ovf_d = q_head_i.ovf;
          end
        end
      end
      ST_OUT: begin
        if (emit_ok) begin
          strobe_d = 1'b1;
          valid_d  = shf_valid;
          slot_d   = shf_slot;
          k_d      = k_q + 1'b1;
          if (is_last) begin
            valid_d = '0;
            state_d = ST_INS;
          end
        end else begin
          valid_d = '0;
          state_d = ST_INS;
        end
      end
      default: begin
        state_d = ST_INS;
        valid_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INS;
      valid_q   <= '0;
      k_q       <= '0;
      set_ovf_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      k_q       <= k_d;
      set_ovf_q <= set_ovf_d;
      strobe_q  <= strobe_d;
    end
  end

  // Ranked payload and result register
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (strobe_d) begin
      idx_q     <= slot_q[0].idx;
      mag_q     <= slot_q[0].mag;
      ovf_res_q <= set_ovf_q;
      last_q    <= is_last;
    end
  end

  assign result_valid_o  = strobe_q;
  assign channel_index_o = idx_q;
  assign magnitude_o     = mag_q;
  assign overflow_o      = ovf_res_q;
  assign last_result_o   = strobe_q && last_q;

  // Checks
  `TKMS_ASSERT_IMPL(a_strobe_from_out, strobe_q, $past(state_q == ST_OUT),
                    "result strobe outside the report phase")
  `TKMS_ASSERT_IMPL(a_no_pop_in_out, state_q == ST_OUT, !q_pop_o,
                    "queue popped while reporting")
  `TKMS_ASSERT_IMPL(a_valid_prefix, 1'b1,
                    (valid_q & TOP_SLOTS'(valid_q + 1'b1)) == '0,
                    "ranking valid bits are not a prefix")
  `TKMS_ASSERT_NEXT(a_last_ends_report, strobe_d && is_last, state_q == ST_INS,
                    "report did not end after its final result")

endmodule

### hdl/top_k_magnitude_selector_unit.sv
// Top level of the top-k magnitude selector: register, front, queue, back.
// Depends on tkms_pkg, tkms_front, tkms_queue and tkms_rank.
//
//  Channel  | Ports                                       | Transfer
//  ---------+---------------------------------------------+------------------------------
//  config   | top_count_we_i, top_count_i                 | edge with we high
//  sample   | start_i, busy_o, sample_i, last_sample_i    | edge with start high, busy low
//  result   | result_valid_o, channel_index_o,            | edge ending the strobe cycle
//           | magnitude_o, overflow_o, last_result_o      |
//
// One sample per cycle enters while the four-entry queue has room; the
// ranking cells insert one queued sample per cycle.
// A set-closing sample is ranked like any other; the back then reports
// min(top_count, TOP_SLOTS, ranked samples) results, or none when that is
// zero, and pops nothing meanwhile, so busy rises once the queue fills.
// With the queue empty, the closing sample passes the queue, the back's state
// register and the result register before its first result is on the ports.
// Reset clears the ranking, counters and queue and sets top_count to 16.
`timescale 1ns / 1ps

module top_k_magnitude_selector_unit #(
  parameter int TOP_SLOTS   = 16,
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 top_count_we_i,
  input  logic [tkms_pkg::TC_W-1:0]            top_count_i,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [tkms_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 last_sample_i,
  output logic                                 result_valid_o,
  output logic [tkms_pkg::IDX_W-1:0]           channel_index_o,
  output logic [tkms_pkg::MAG_W-1:0]           magnitude_o,
  output logic                                 overflow_o,
  output logic                                 last_result_o
);
  import tkms_pkg::*;

  logic [TC_W-1:0] top_count_q;
  logic            accept;
  logic            push, full, q_valid, q_pop;
  tkms_item_t      item, head;

  // Hold the report size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= TOP_COUNT_RST;
    end else if (top_count_we_i) begin
      top_count_q <= top_count_i;
    end
  end

  assign busy_o = full;
  assign accept = start_i && !busy_o;

  tkms_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .sample_i     (sample_i),
    .last_sample_i(last_sample_i),
    .push_o       (push),
    .item_o       (item)
  );

  tkms_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .head_o (head)
  );

  tkms_rank #(
    .TOP_SLOTS(TOP_SLOTS)
  ) u_rank (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .top_count_i    (top_count_q),
    .q_valid_i      (q_valid),
    .q_head_i       (head),
    .q_pop_o        (q_pop),
    .result_valid_o (result_valid_o),
    .channel_index_o(channel_index_o),
    .magnitude_o    (magnitude_o),
    .overflow_o     (overflow_o),
    .last_result_o  (last_result_o)
  );

endmodule

### tb/sv/top_k_magnitude_selector_unit_tb.sv
// Self-checking testbench for top_k_magnitude_selector_unit: drives sample sets,
// predicts the ranked channel report and checks every result strobe.
// Depends on tkms_pkg and the top_k_magnitude_selector_unit RTL.
`timescale 1ns / 1ps

module top_k_magnitude_selector_unit_tb;
  import tkms_pkg::*;

  localparam int TOP_SLOTS    = 16;
  localparam int MAX_SAMPLES  = 4096;
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 270;

  // Sample content styles for random sets
  localparam int MODE_FULL    = 0;
  localparam int MODE_TIES    = 1;
  localparam int MODE_EXTREME = 2;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [MAG_W-1:0] mag;
    logic             ovf;
    logic             last;
  } chan_report_t;

  // Ranking predictor plus the queue of channel reports still to arrive
  class topk_scoreboard;
    tkms_slot_t       ranking[TOP_SLOTS];
    int unsigned      fill_cnt;
    int unsigned      in_set;
    bit               ovf_seen;
    logic [TC_W-1:0]  top_count;
    chan_report_t     pending_reports[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      sets_closed;

    function new();
      fill_cnt      = 0;
      in_set        = 0;
      ovf_seen      = 0;
      top_count     = TOP_COUNT_RST;
      errors        = 0;
      checked       = 0;
      sets_closed   = 0;
    endfunction

    function void set_top_count(logic [TC_W-1:0] v);
      top_count = v;
    endfunction

    function int unsigned outstanding();
      return pending_reports.size();
    endfunction

    // Insert behind every entry of equal or larger magnitude; drop off the tail
    function void rank_insert(logic [IDX_W-1:0] idx, logic [MAG_W-1:0] mag);
      int unsigned pos;
      int unsigned k;
      pos = 0;
      while (pos < fill_cnt && ranking[pos].mag >= mag) pos++;
      if (pos >= TOP_SLOTS) return;
      k = (fill_cnt < TOP_SLOTS) ? fill_cnt : TOP_SLOTS - 1;
      while (k > pos) begin
        ranking[k] = ranking[k-1];
        k--;
      end
      ranking[pos].idx = idx;
      ranking[pos].mag = mag;
      if (fill_cnt < TOP_SLOTS) fill_cnt++;
    endfunction

    // Account for one sample transfer; a set-closing sample queues its report
    function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic last);
      logic [MAG_W-1:0] raw;
      logic [MAG_W-1:0] mag;
      int unsigned      n;
      chan_report_t     r;
      raw = smp;
      mag = raw[MAG_W-1] ? -raw : raw;
      if (in_set < MAX_SAMPLES) begin
        rank_insert(in_set[IDX_W-1:0], mag);
        in_set++;
      end else begin
        ovf_seen = 1;
      end
      if (!last) return;
      n = (top_count > TOP_SLOTS) ? TOP_SLOTS : top_count;
      if (n > fill_cnt) n = fill_cnt;
      for (int unsigned i = 0; i < n; i++) begin
        r.idx  = ranking[i].idx;
        r.mag  = ranking[i].mag;
        r.ovf  = ovf_seen;
        r.last = (i + 1 == n);
        pending_reports.push_back(r);
      end
      sets_closed++;
      fill_cnt = 0;
      in_set   = 0;
      ovf_seen = 0;
    endfunction

    // Compare one result transfer with the oldest pending report
    function void check_result(chan_report_t got);
      chan_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result idx=%0d mag=%0d ovf=%0b last=%0b",
                 $time, got.idx, got.mag, got.ovf, got.last);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      if (got.idx !== want.idx) begin
        $display("%0t: channel_index expected %0d actual %0d", $time, want.idx, got.idx);
        errors++;
      end
      if (got.mag !== want.mag) begin
        $display("%0t: magnitude expected %0d actual %0d", $time, want.mag, got.mag);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, got.ovf);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_result expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       top_count_we_i = 1'b0;
  logic [TC_W-1:0]            top_count_i    = TOP_COUNT_RST;
  logic                       start_i        = 1'b0;
  logic                       busy_o;
  logic signed [SAMPLE_W-1:0] sample_i       = '0;
  logic                       last_sample_i  = 1'b0;
  logic                       result_valid_o;
  logic [IDX_W-1:0]           channel_index_o;
  logic [MAG_W-1:0]           magnitude_o;
  logic                       overflow_o;
  logic                       last_result_o;

  topk_scoreboard sb = new();
  int unsigned    burst_left    = 0;
  int unsigned    items_sent    = 0;
  int unsigned    settings_used = 0;
  int unsigned    cycles        = 0;

  top_k_magnitude_selector_unit #(
    .TOP_SLOTS  (TOP_SLOTS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .top_count_we_i (top_count_we_i),
    .top_count_i    (top_count_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_i       (sample_i),
    .last_sample_i  (last_sample_i),
    .result_valid_o (result_valid_o),
    .channel_index_o(channel_index_o),
    .magnitude_o    (magnitude_o),
    .overflow_o     (overflow_o),
    .last_result_o  (last_result_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d reports pending", $time, sb.outstanding());
      $display("[top_k_magnitude_selector_unit] ERROR");
      $finish;
    end
  end

  // Observe both channels at every edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o)
        sb.check_result(chan_report_t'{channel_index_o, magnitude_o, overflow_o,
                                       last_result_o});
      if (start_i && !busy_o) sb.note_sample(sample_i, last_sample_i);
    end
  end

  // Offer one sample and hold it until the transfer; insert gaps between bursts
  task automatic send_item(logic signed [SAMPLE_W-1:0] smp, logic last);
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
    start_i       <= 1'b1;
    sample_i      <= smp;
    last_sample_i <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending and wait until every pending report has arrived
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Write top_count while the block is idle
  task automatic write_top_count(logic [TC_W-1:0] v);
    drain();
    top_count_we_i <= 1'b1;
    top_count_i    <= v;
    @(posedge clk_i);
    top_count_we_i <= 1'b0;
    sb.set_top_count(v);
    settings_used++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int mode);
    logic signed [SAMPLE_W-1:0] v;
    case (mode)
      MODE_TIES: begin
        v = SAMPLE_W'($urandom_range(0, 6));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      MODE_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2:       v = 16'sh8001;
          3:       v = 16'sh0000;
          4:       v = 16'shFFFF;
          default: v = 16'sh0001;
        endcase
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  // One complete set of random length and style
  task automatic send_random_set();
    int unsigned len;
    int          mode;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
    mode = ($urandom_range(0, 3) < 2) ? MODE_FULL
         : ($urandom_range(0, 1) != 0) ? MODE_TIES : MODE_EXTREME;
    for (int unsigned i = 0; i < len; i++)
      send_item(pick_sample(mode), i == len - 1);
  endtask

  initial begin
    logic [TC_W-1:0] tc_plan[7];
    int unsigned     plan_pos;
    int unsigned     sets;
    int unsigned     base;
    tc_plan  = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd2, 5'd15};
    plan_pos = 0;
    sets     = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes under the reset top_count, a one-sample set, ties with eviction
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'shFFFF, 1'b0);
    send_item(16'sh0001, 1'b0);
    send_item(-16'sd5, 1'b0);
    send_item(16'sd5, 1'b0);
    send_item(16'sh8001, 1'b1);
    send_item(16'sh0000, 1'b1);
    for (int unsigned i = 0; i < 18; i++)
      send_item((i % 3 == 0) ? 16'sd100 : (i % 3 == 1) ? -16'sd100 : 16'(i), i == 17);

    // Random sets across several top_count settings, with a drain now and then between sets
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (sets % 5 == 0) begin
        write_top_count(plan_pos < 7 ? tc_plan[plan_pos] : 5'($urandom_range(0, 31)));
        plan_pos++;
      end else if (sets % 7 == 3) begin
        drain();
      end
      send_random_set();
      sets++;
    end

    drain();
    $display("Sent %0d samples in %0d sets over %0d top_count writes;",
             items_sent, sb.sets_closed, settings_used);
    $display("checked %0d channel reports, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("[top_k_magnitude_selector_unit] OK");
    end else begin
      $display("[top_k_magnitude_selector_unit] ERROR");
    end
    $finish;
  end

endmodule
